// ===== rtl/core/chbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// chbmc_pkg
// Types and constants for the interleaved chroma bilinear interpolator.
// ----------------------------------------------------------------------------
package chbmc_pkg;

	// input beat: one reference sample plus block settings and framing
	typedef struct packed {
		logic [7:0] ref_sample;
		logic [2:0] frac_x;
		logic [2:0] frac_y;
		logic [1:0] width_code;
		logic       block_start;
		logic       block_end;
	} chbmc_in_t;

	// output beat: one prediction sample
	typedef struct packed {
		logic [7:0] pred_sample;
		logic       component;
		logic       is_last;
	} chbmc_out_t;

	// width codes
	localparam logic [1:0] WIDTH_CODE_2 = 2'd0;
	localparam logic [1:0] WIDTH_CODE_4 = 2'd1;
	localparam logic [1:0] WIDTH_CODE_8 = 2'd2;

	// eighth-pel arithmetic
	localparam logic [3:0] FRAC_ONE   = 4'd8;
	localparam int         WEIGHT_W   = 7;
	localparam int         ROUND_BIAS = 32;
	localparam int         OUT_SHIFT  = 6;

	// bilinear tap weight (8-x or x) times (8-y or y); max 64
	function automatic logic [WEIGHT_W-1:0] tap_weight(
		input logic [3:0] fa,
		input logic [3:0] fb
	);
		return WEIGHT_W'({3'b000, fa} * {3'b000, fb});
	endfunction

endpackage

// ===== rtl/core/chroma_bilinear_mc_interleaved_core.sv =====
// ----------------------------------------------------------------------------
// chroma_bilinear_mc_interleaved_core
// Eighth-pel bilinear chroma interpolator over interleaved U/V samples.
// ----------------------------------------------------------------------------
// pipeline: an accepted sample beat moves through stage 1, stage 2 and the output
//   register, where a result beat it produces is held until it is taken
// throughput: one sample beat per cycle; the pipe moves as one unit and halts
//   only while the output register holds a beat that is not taken
// reset: arst_n clears counters, held settings, delays and stage valids;
//   the line store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module chroma_bilinear_mc_interleaved_core #(
	parameter int MAX_BLOCK_WIDTH = 8,
	parameter int SAMPLE_BITS     = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  chbmc_pkg::chbmc_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output chbmc_pkg::chbmc_out_t  out_data
);

	import chbmc_pkg::*;

	// line store holds one full row of interleaved samples
	localparam int LINE_DEPTH = 2 * MAX_BLOCK_WIDTH + 2;
	localparam int CW         = $clog2(LINE_DEPTH);
	localparam int LW         = $clog2(LINE_DEPTH + 1);
	localparam int PW         = SAMPLE_BITS + WEIGHT_W;
	localparam int SUMW       = PW + 2;

	// row lengths per width code, clamped to the line store
	localparam int W2_PIX = (2 > MAX_BLOCK_WIDTH) ? MAX_BLOCK_WIDTH : 2;
	localparam int W4_PIX = (4 > MAX_BLOCK_WIDTH) ? MAX_BLOCK_WIDTH : 4;
	localparam int W8_PIX = (8 > MAX_BLOCK_WIDTH) ? MAX_BLOCK_WIDTH : 8;
	localparam logic [LW-1:0] LEN_2 = LW'(2 * W2_PIX + 2);
	localparam logic [LW-1:0] LEN_4 = LW'(2 * W4_PIX + 2);
	localparam logic [LW-1:0] LEN_8 = LW'(2 * W8_PIX + 2);

	// ---------------------------------------------------------------------
	// global advance: every stage moves when the output register frees up
	// ---------------------------------------------------------------------
	logic advance;
	logic accept;

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// ---------------------------------------------------------------------
	// stage 0: window tracking, settings and line store read
	// ---------------------------------------------------------------------
	logic [LW-1:0]       col_q;      // column count within the row
	logic                seen_q;     // a full row has been stored
	logic [LW-1:0]       len_q;      // held row length in samples
	logic [WEIGHT_W-1:0] wa_q, wb_q, wc_q, wd_q;

	logic [LW-1:0]       len_new;
	logic [LW-1:0]       len_eff;
	logic [LW-1:0]       cnt_eff;
	logic [LW-1:0]       col;
	logic                seen_eff;
	logic                produce;
	logic [3:0]          fx, fy, fxn, fyn;
	logic [WEIGHT_W-1:0] wa_eff, wb_eff, wc_eff, wd_eff;

	always_comb begin
		unique case (in_data.width_code)
			WIDTH_CODE_2: len_new = LEN_2;
			WIDTH_CODE_4: len_new = LEN_4;
			default:      len_new = LEN_8;   // code 8 and the unused code
		endcase
	end

	assign fx  = {1'b0, in_data.frac_x};
	assign fy  = {1'b0, in_data.frac_y};
	assign fxn = FRAC_ONE - fx;
	assign fyn = FRAC_ONE - fy;

	// a start beat takes its own settings right away
	assign len_eff  = in_data.block_start ? len_new : len_q;
	assign cnt_eff  = in_data.block_start ? '0 : col_q;
	assign seen_eff = in_data.block_start ? 1'b0 : seen_q;
	assign col      = (cnt_eff >= len_eff) ? '0 : cnt_eff;
	assign produce  = seen_eff && (col >= LW'(2));

	assign wa_eff = in_data.block_start ? tap_weight(fxn, fyn) : wa_q;
	assign wb_eff = in_data.block_start ? tap_weight(fx, fyn)  : wb_q;
	assign wc_eff = in_data.block_start ? tap_weight(fxn, fy)  : wc_q;
	assign wd_eff = in_data.block_start ? tap_weight(fx, fy)   : wd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			seen_q <= 1'b0;
			len_q  <= LEN_2;
			// zero fractions: plain copy of the top-left tap
			wa_q   <= WEIGHT_W'(64);
			wb_q   <= '0;
			wc_q   <= '0;
			wd_q   <= '0;
		end else if (accept) begin
			len_q <= len_eff;
			wa_q  <= wa_eff;
			wb_q  <= wb_eff;
			wc_q  <= wc_eff;
			wd_q  <= wd_eff;
			if (in_data.block_end) begin
				col_q  <= '0;
				seen_q <= 1'b0;
			end else if ((col + LW'(1)) >= len_eff) begin
				col_q  <= '0;
				seen_q <= 1'b1;
			end else begin
				col_q  <= col + LW'(1);
				seen_q <= seen_eff;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 1: above sample arrives from the line store, write back
	// ---------------------------------------------------------------------
	logic                   valid_s1;
	logic                   prod_s1;
	logic                   last_s1;
	logic [CW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] d_s1;
	logic [WEIGHT_W-1:0]    wa_s1, wb_s1, wc_s1, wd_s1;
	logic                   fwd_s1;
	logic [SAMPLE_BITS-1:0] fwd_data_s1;

	logic                   ram_we;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] above;

	// previous-row taps (row delay) and current-row taps two back
	logic [SAMPLE_BITS-1:0] prev0_q, prev1_q;
	logic [SAMPLE_BITS-1:0] cur0_q, cur1_q;

	assign ram_we = advance && valid_s1;

	chbmc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (d_s1),
		.re    (accept),
		.raddr (col[CW-1:0]),
		.rdata (ram_rdata)
	);

	// same-entry read right behind a write sees the new sample
	assign above = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			fwd_s1   <= accept && ram_we && (addr_s1 == col[CW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1     <= produce;
			last_s1     <= in_data.block_end;
			addr_s1     <= col[CW-1:0];
			d_s1        <= SAMPLE_BITS'(in_data.ref_sample);
			wa_s1       <= wa_eff;
			wb_s1       <= wb_eff;
			wc_s1       <= wc_eff;
			wd_s1       <= wd_eff;
			fwd_data_s1 <= d_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev0_q <= '0;
			prev1_q <= '0;
			cur0_q  <= '0;
			cur1_q  <= '0;
		end else if (ram_we) begin
			prev0_q <= above;
			prev1_q <= prev0_q;
			cur0_q  <= d_s1;
			cur1_q  <= cur0_q;
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: four tap products
	// ---------------------------------------------------------------------
	logic          valid_s2;
	logic          prod_s2;
	logic          last_s2;
	logic          comp_s2;
	logic [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= prod_s1;
			last_s2 <= last_s1;
			comp_s2 <= addr_s1[0];     // column parity picks U or V
			pa_s2   <= PW'(wa_s1) * PW'(prev1_q);
			pb_s2   <= PW'(wb_s1) * PW'(above);
			pc_s2   <= PW'(wc_s1) * PW'(cur1_q);
			pd_s2   <= PW'(wd_s1) * PW'(d_s1);
		end
	end

	// ---------------------------------------------------------------------
	// stage 3: sum, round, shift into the output register
	// ---------------------------------------------------------------------
	logic [SUMW-1:0] sum;
	logic            out_valid_q;
	chbmc_out_t      out_data_q;

	assign sum = SUMW'(pa_s2) + SUMW'(pb_s2) + SUMW'(pc_s2) + SUMW'(pd_s2)
		+ SUMW'(ROUND_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2 && prod_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.pred_sample <= 8'(sum >> OUT_SHIFT);
			out_data_q.component   <= comp_s2;
			out_data_q.is_last     <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < len_q)
		else $error("column count past row length");

	a_ram_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> $stable(ram_rdata))
		else $error("line store read data moved during stall");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.block_end |=> (col_q == '0) && !seen_q)
		else $error("window tracking not restarted after end beat");

	a_no_fwd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forward flag without a stage-1 beat");

endmodule

// ===== rtl/core/chbmc_ram.sv =====
// ----------------------------------------------------------------------------
// chbmc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module chbmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
